>>> sv/positional_list_engine_macros.svh
// Assertion macros for the positional list engine datapath.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Clocked check that is ignored while reset is applied.
`define PLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is applied.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ple_pkg.sv
// Types and codes shared by the positional list engine modules.
`default_nettype none

package ple_pkg;

    // Command codes carried in the request.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // Status codes returned in the response.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } stat_t;

    localparam int COUNT_W = 7;

    // Request payload.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] item_value;
        logic signed [15:0] slot_index;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic signed [31:0]   read_value;
        logic [1:0]           status;
        logic [COUNT_W-1:0]   entry_count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decide;
        logic rd_pos;
        logic grab;
        logic sweep_start;
        logic shift;
        logic put;
        logic emit;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_ok;
        cmd_t cmd;
        logic at_end;
        logic one_left;
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> sv/ple_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/ple_ctrl.sv
// Controller state machine that sequences each command of the list engine.
`default_nettype none

module ple_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_stall,
    input  wire ple_pkg::sts_t sts,
    output      ple_pkg::ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GRAB,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctl.load = req_valid;
                if (req_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.decide = 1'b1;
                if (!sts.op_ok)
                begin
                    state_next = S_RESP;
                end
                else if (sts.cmd == ple_pkg::CMD_INSERT)
                begin
                    if (sts.at_end)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ctl.sweep_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
                else
                begin
                    ctl.rd_pos = 1'b1;
                    state_next = S_GRAB;
                end
            end
            S_GRAB:
            begin
                ctl.grab = 1'b1;
                if (sts.cmd == ple_pkg::CMD_REMOVE && !sts.one_left)
                begin
                    ctl.sweep_start = 1'b1;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT:
            begin
                ctl.shift = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (sts.cmd == ple_pkg::CMD_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_PUT:
            begin
                ctl.put    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                ctl.emit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new request is taken only between commands.
    assign req_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> sv/ple_dp.sv
// Datapath of the list engine: request register, entry RAM, shift sweep and result register.
`default_nettype none

`include "positional_list_engine_macros.svh"

module ple_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ple_pkg::req_t req_data,
    output      logic          rsp_valid,
    input  wire logic          rsp_stall,
    output      ple_pkg::rsp_t rsp_data,
    input  wire ple_pkg::ctl_t ctl,
    output      ple_pkg::sts_t sts
);

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = (LEN_W > 15) ? LEN_W : 15;

    ple_pkg::req_t       req_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic [ADDR_W-1:0]   cursor_reg;
    logic [ADDR_W-1:0]   wr_addr_reg;
    logic                pend_reg;
    logic                ok_reg;
    logic [1:0]          status_reg;
    logic [31:0]         val_reg;
    logic                out_valid_reg;
    ple_pkg::rsp_t       out_reg;

    logic                is_ins;
    logic                neg;
    logic                empty;
    logic                full;
    logic [CMP_W-1:0]    pos_c;
    logic [CMP_W-1:0]    len_c;
    logic [ADDR_W-1:0]   pos_eff;
    logic [ADDR_W-1:0]   len_m1;
    logic                op_ok;
    ple_pkg::stat_t      code;
    logic [31:0]         rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [31:0]         ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic                out_free;

    // Position and length comparisons for the registered request.
    assign is_ins  = (req_reg.cmd == ple_pkg::CMD_INSERT);
    assign neg     = req_reg.slot_index[15];
    assign empty   = (len_reg == '0);
    assign full    = (len_reg == LEN_W'(CAPACITY));
    assign pos_c   = CMP_W'(req_reg.slot_index[14:0]);
    assign len_c   = CMP_W'(len_reg);
    assign pos_eff = empty ? '0 : ADDR_W'(req_reg.slot_index[14:0]);
    assign len_m1  = ADDR_W'(len_reg - 1'b1);

    // Outcome of the command, with the checks in priority order.
    always_comb
    begin
        code  = ple_pkg::ST_OK;
        op_ok = 1'b0;
        case (req_reg.cmd)
            ple_pkg::CMD_INSERT:
            begin
                if (neg)
                begin
                    code = ple_pkg::ST_BADPOS;
                end
                else if (full)
                begin
                    code = ple_pkg::ST_FULL;
                end
                else if (!empty && pos_c > len_c)
                begin
                    code = ple_pkg::ST_BADPOS;
                end
                else
                begin
                    op_ok = 1'b1;
                end
            end
            ple_pkg::CMD_REMOVE, ple_pkg::CMD_GET:
            begin
                if (neg)
                begin
                    code = ple_pkg::ST_BADPOS;
                end
                else if (empty)
                begin
                    code = ple_pkg::ST_EMPTY;
                end
                else if (pos_c >= len_c)
                begin
                    code = ple_pkg::ST_BADPOS;
                end
                else
                begin
                    op_ok = 1'b1;
                end
            end
            default:
            begin
                code  = ple_pkg::ST_OK;
                op_ok = 1'b0;
            end
        endcase
    end

    // Status back to the controller.
    assign out_free       = !out_valid_reg || !rsp_stall;
    assign sts.op_ok      = op_ok;
    assign sts.cmd        = ple_pkg::cmd_t'(req_reg.cmd);
    assign sts.at_end     = empty || (pos_c == len_c);
    assign sts.one_left   = (pos_eff == len_m1);
    assign sts.sweep_last = is_ins ? (cursor_reg == pos_eff) : (cursor_reg == len_m1);
    assign sts.out_free   = out_free;

    // Entry RAM ports: the sweep reads one entry a cycle and writes it one place over
    // in the next cycle; the inserted value goes in last.
    assign ram_re    = ctl.rd_pos || ctl.shift;
    assign ram_raddr = ctl.shift ? cursor_reg : pos_eff;
    assign ram_we    = pend_reg || ctl.put;
    assign ram_waddr = ctl.put ? pos_eff : wr_addr_reg;
    assign ram_wdata = ctl.put ? req_reg.item_value : rdata;

    ple_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Length after the command completes.
    always_comb
    begin
        len_next = len_reg;
        if (ok_reg && req_reg.cmd == ple_pkg::CMD_INSERT)
        begin
            len_next = len_reg + 1'b1;
        end
        else if (ok_reg && req_reg.cmd == ple_pkg::CMD_REMOVE)
        begin
            len_next = len_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.shift;
            if (ctl.emit)
            begin
                len_reg <= len_next;
            end
            out_valid_reg <= ctl.emit || (out_valid_reg && rsp_stall);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= req_data;
        end
        if (ctl.decide)
        begin
            status_reg <= code;
            ok_reg     <= op_ok;
            val_reg    <= '0;
        end
        if (ctl.grab)
        begin
            val_reg <= rdata;
        end
        if (ctl.sweep_start)
        begin
            cursor_reg <= is_ins ? len_m1 : ADDR_W'(pos_eff + 1'b1);
        end
        else if (ctl.shift)
        begin
            cursor_reg <= is_ins ? ADDR_W'(cursor_reg - 1'b1) : ADDR_W'(cursor_reg + 1'b1);
        end
        if (ctl.shift)
        begin
            wr_addr_reg <= is_ins ? ADDR_W'(cursor_reg + 1'b1) : ADDR_W'(cursor_reg - 1'b1);
        end
        if (ctl.emit)
        begin
            out_reg.read_value  <= val_reg;
            out_reg.status      <= status_reg;
            out_reg.entry_count <= ple_pkg::COUNT_W'(len_next);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // The length never exceeds the capacity.
    `PLE_ASSERT(a_len_range, (len_reg <= LEN_W'(CAPACITY)), "length above capacity")
    // A sweep read always lies inside the stored entries.
    `PLE_ASSERT(a_cursor_range, (ctl.shift |-> LEN_W'(cursor_reg) < len_reg), "sweep out of range")
    // The value write never collides with a pending sweep write.
    `PLE_ASSERT(a_port_clash, (!(pend_reg && ctl.put)), "write port collision")
    // A finished insert grows the list by one entry.
    `PLE_ASSERT(a_ins_grow, (ctl.emit && ok_reg && is_ins |=> len_reg == LEN_W'($past(len_reg) + 1'b1)), "insert did not grow list")

endmodule

`default_nettype wire

>>> sv/positional_list_engine.sv
// Top level of the positional list engine: a bounded ordered list of signed 32-bit values.
//
// Usage: a request transfer on req_valid/req_data carries one command (insert, remove
// or get, with a value and a position); each request gives exactly one response
// transfer on rsp_valid/rsp_data with the read value, a status code and the count of
// entries held afterward. A transfer takes place when valid is high and stall is low.
// Commands are handled one at a time. The single entry RAM moves one entry per cycle,
// so inserts and removes that move more entries take longer. The response is
// registered and appears in the cycle after the command completes. Reset clears the
// length to zero and drops any pending response; entry contents are left as they are.
// If the receiver stalls, the response is held stable, the next request is still
// taken, and that command waits at its end until the output register is free.
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_stall,
    input  wire ple_pkg::req_t req_data,
    output      logic          rsp_valid,
    input  wire logic          rsp_stall,
    output      ple_pkg::rsp_t rsp_data
);

    ple_pkg::ctl_t ctl;
    ple_pkg::sts_t sts;

    // Command sequencer.
    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Storage and result datapath.
    ple_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the positional list engine with a shadow list predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int CAP        = 64;
    // Cycles to wait after the last response; covers the longest shifting command.
    localparam int SETTLE     = 2 * CAP + 16;
    localparam int MAX_CYCLES = 1000000;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    ple_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_stall;
    ple_pkg::rsp_t rsp_data;

    // Shadow copy of the list and the responses it predicts.
    logic signed [31:0] shadow_list [CAP];
    int                 shadow_len  = 0;
    ple_pkg::rsp_t      pending_rsp [$];
    ple_pkg::rsp_t      head_rsp;

    int fail_count  = 0;
    int cycle_count = 0;
    bit quiet       = 1'b0;
    int gap_odds    = 20;
    int stall_odds  = 15;

    positional_list_engine #(.CAPACITY(CAP)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #6 clk = ~clk;

    // Applies one command to the shadow list and returns the response it should give.
    function automatic ple_pkg::rsp_t list_apply(ple_pkg::req_t r);
        ple_pkg::rsp_t res;
        int            pos;
        res        = '0;
        res.status = ple_pkg::ST_OK;
        pos        = int'(r.slot_index);
        if (r.cmd == ple_pkg::CMD_NOP)
        begin
            // The unused command leaves the list alone.
        end
        else if (pos < 0)
        begin
            res.status = ple_pkg::ST_BADPOS;
        end
        else if (r.cmd == ple_pkg::CMD_INSERT)
        begin
            if (shadow_len >= CAP)
                res.status = ple_pkg::ST_FULL;
            else
            begin
                // An insert into an empty list always lands at the front.
                if (shadow_len == 0)
                    pos = 0;
                if (pos > shadow_len)
                    res.status = ple_pkg::ST_BADPOS;
                else
                begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos] = r.item_value;
                    shadow_len++;
                end
            end
        end
        else if (shadow_len == 0)
        begin
            res.status = ple_pkg::ST_EMPTY;
        end
        else if (pos >= shadow_len)
        begin
            res.status = ple_pkg::ST_BADPOS;
        end
        else
        begin
            res.read_value = shadow_list[pos];
            if (r.cmd == ple_pkg::CMD_REMOVE)
            begin
                for (int i = pos; i < shadow_len - 1; i++)
                    shadow_list[i] = shadow_list[i + 1];
                shadow_len--;
            end
        end
        res.entry_count = ple_pkg::COUNT_W'(shadow_len);
        return res;
    endfunction

    // Position mostly in the legal range, with edges and out-of-range noise.
    function automatic logic signed [15:0] pick_slot(ple_pkg::cmd_t op);
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = (op == ple_pkg::CMD_INSERT) ? shadow_len : shadow_len - 1;
        if (roll < 5)
            return {1'b1, 15'($urandom)};
        if (roll < 10)
            return 16'($urandom_range(0, 32767));
        if (roll < 16)
            return 16'(shadow_len + $urandom_range(0, 1));
        if (top < 0)
            return '0;
        return 16'($urandom_range(0, top));
    endfunction

    // Random data word with the extremes showing up now and then.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Drives one request transfer and records the expected response on acceptance.
    task automatic send_cmd(input ple_pkg::cmd_t op, input logic signed [31:0] value,
                            input logic signed [15:0] slot);
        ple_pkg::req_t r;
        r.cmd        = op;
        r.item_value = value;
        r.slot_index = slot;
        if (!quiet && $urandom_range(0, 99) < gap_odds)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_data  <= r;
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        pending_rsp.push_back(list_apply(r));
        @(negedge clk);
    endtask

    // Random command stream; grow sets the share of inserts in percent.
    task automatic run_random_mix(input int count, input int grow);
        ple_pkg::cmd_t op;
        int            roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = ple_pkg::CMD_NOP;
            else if (roll < 3 + grow)
                op = ple_pkg::CMD_INSERT;
            else if ($urandom_range(0, 1) == 1)
                op = ple_pkg::CMD_REMOVE;
            else
                op = ple_pkg::CMD_GET;
            send_cmd(op, pick_value(), pick_slot(op));
        end
    endtask

    // Commands against an empty list, ending with an insert far past the end.
    task automatic test_empty_list();
        send_cmd(ple_pkg::CMD_GET, 32'sd5, 16'sd0);
        send_cmd(ple_pkg::CMD_REMOVE, 32'sd0, 16'sd0);
        send_cmd(ple_pkg::CMD_REMOVE, 32'sd0, -16'sd1);
        send_cmd(ple_pkg::CMD_NOP, 32'sd0, 16'sd0);
        send_cmd(ple_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF);
    endtask

    // Appends, inserts at both ends and in the middle, and out-of-range cases.
    task automatic test_position_edges();
        send_cmd(ple_pkg::CMD_INSERT, 32'sh8000_0000, 16'sd1);
        send_cmd(ple_pkg::CMD_INSERT, 32'sd0, 16'sd3);
        send_cmd(ple_pkg::CMD_INSERT, -32'sd1, 16'sd0);
        send_cmd(ple_pkg::CMD_INSERT, 32'sh5A5A_5A5A, 16'sd1);
        send_cmd(ple_pkg::CMD_GET, 32'sd0, 16'sd3);
        send_cmd(ple_pkg::CMD_GET, 32'sd0, 16'sd0);
        send_cmd(ple_pkg::CMD_GET, 32'sd0, 16'sd4);
        send_cmd(ple_pkg::CMD_REMOVE, 32'sd0, 16'sd4);
        send_cmd(ple_pkg::CMD_GET, 32'sd0, 16'sh8000);
        send_cmd(ple_pkg::CMD_INSERT, 32'sd7, 16'sh8000);
        send_cmd(ple_pkg::CMD_NOP, '1, '1);
        send_cmd(ple_pkg::CMD_REMOVE, 32'sd0, 16'sd1);
        send_cmd(ple_pkg::CMD_REMOVE, 32'sd0, 16'sd2);
        send_cmd(ple_pkg::CMD_GET, '1, 16'sh7FFF);
        send_cmd(ple_pkg::CMD_REMOVE, 32'sd0, 16'sd0);
        send_cmd(ple_pkg::CMD_REMOVE, 32'sd0, 16'sd0);
    endtask

    // Fills the list to capacity, probes the full case, then empties it again.
    task automatic test_fill_and_empty();
        gap_odds   = 30;
        stall_odds = 20;
        while (shadow_len < CAP)
            send_cmd(ple_pkg::CMD_INSERT, pick_value(), 16'($urandom_range(0, shadow_len)));
        send_cmd(ple_pkg::CMD_INSERT, pick_value(), 16'(CAP));
        send_cmd(ple_pkg::CMD_INSERT, pick_value(), 16'sd0);
        send_cmd(ple_pkg::CMD_INSERT, pick_value(), -16'sd2);
        send_cmd(ple_pkg::CMD_GET, pick_value(), 16'(CAP - 1));
        send_cmd(ple_pkg::CMD_GET, pick_value(), 16'(CAP));
        while (shadow_len > 0)
            send_cmd(ple_pkg::CMD_REMOVE, pick_value(),
                     16'($urandom_range(0, shadow_len - 1)));
    endtask

    // Alternating growth and shrink phases with varying idle pressure.
    task automatic test_random_traffic();
        repeat (5)
        begin
            gap_odds   = $urandom_range(0, 40);
            stall_odds = $urandom_range(0, 30);
            run_random_mix(100, 65);
            gap_odds   = $urandom_range(0, 40);
            stall_odds = $urandom_range(0, 30);
            run_random_mix(100, 20);
        end
    endtask

    // Full-rate traffic with no idling on either side.
    task automatic test_back_to_back();
        quiet = 1'b1;
        run_random_mix(60, 65);
        run_random_mix(60, 25);
    endtask

    // Lets the last responses arrive, then watches for stray ones.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Response stall in random bursts.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 99) < stall_odds)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            rsp_stall <= 1'b0;
        end
    end

    // Compare every response transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response transfer with none expected: value %0d status %0d count %0d",
                         $time, rsp_data.read_value, rsp_data.status, rsp_data.entry_count);
                fail_count++;
            end
            else
            begin
                head_rsp = pending_rsp.pop_front();
                if (rsp_data.read_value !== head_rsp.read_value)
                begin
                    $display("%0t: read_value mismatch, expected %0d, got %0d",
                             $time, head_rsp.read_value, rsp_data.read_value);
                    fail_count++;
                end
                if (rsp_data.status !== head_rsp.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, head_rsp.status, rsp_data.status);
                    fail_count++;
                end
                if (rsp_data.entry_count !== head_rsp.entry_count)
                begin
                    $display("%0t: entry_count mismatch, expected %0d, got %0d",
                             $time, head_rsp.entry_count, rsp_data.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("positional_list_engine test failed");
            $finish;
        end
    end

    // Reset once, then run the tests in turn.
    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_list();
        test_position_edges();
        test_fill_and_empty();
        test_random_traffic();
        test_back_to_back();
        wait_for_drain();
        if (fail_count == 0)
            $display("positional_list_engine test passed");
        else
            $display("positional_list_engine test failed");
        $finish;
    end

endmodule
